@@ rtl/bdc_pkg.sv @@
package bdc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEBOUNCE_TIME = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_LOW    = 2'd1;
    localparam logic [1:0] CFG_CLICK_WINDOW  = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CD_W        = 18;

    // Reset values of the configuration registers.
    localparam logic [15:0] DEBOUNCE_TIME_RST = 16'd50;
    localparam logic        ACTIVE_LOW_RST    = 1'b0;
    localparam logic [15:0] CLICK_WINDOW_RST  = 16'd1000;

    // One input item: a timestamped sample of the button level.
    typedef struct packed {
        logic        level;
        logic [31:0] now_ms;
    } bdc_in_t;

    // One result item.
    typedef struct packed {
        logic settled;
        logic value;
        logic pressed;
        logic released;
        logic clicked;
    } bdc_out_t;

    // Configuration seen by the update logic.
    typedef struct packed {
        logic [15:0] debounce_time;
        logic        active_low;
        logic [15:0] click_window;
    } bdc_cfg_t;

    // Debouncer and edge detector state carried from item to item.
    typedef struct packed {
        logic                   prev_sample;
        logic signed [CD_W-1:0] countdown;
        logic [31:0]            prev_time;
        logic                   settled_flag;
        logic                   prev_settled_level;
        logic                   press_done;
        logic                   release_done;
        logic                   click_done;
        logic [31:0]            press_start;
    } bdc_state_t;

endpackage

@@ rtl/bdc_step.sv @@
module bdc_step (
    input  bdc_pkg::bdc_cfg_t   cfg,
    input  bdc_pkg::bdc_state_t state,
    input  bdc_pkg::bdc_in_t    item,
    output bdc_pkg::bdc_state_t state_next,
    output bdc_pkg::bdc_out_t   result
);
    import bdc_pkg::*;

    logic        act;
    logic        inact;
    logic [31:0] elapsed;
    logic [31:0] press_dur;
    logic [31:0] cd_wide;

    assign act       = ~cfg.active_low;
    assign inact     = cfg.active_low;
    assign elapsed   = item.now_ms - state.prev_time;
    assign press_dur = item.now_ms - state.press_start;
    assign cd_wide   = {{(32 - CD_W + 1){1'b0}}, state.countdown[CD_W-2:0]};

    always_comb
    begin
        state_next = state;
        result     = '0;

        // Countdown update: a stable level runs the countdown down, a change reloads it.
        if (item.level == state.prev_sample)
        begin
            if (!state.countdown[CD_W-1])
            begin
                if (elapsed > cd_wide)
                begin
                    state_next.countdown = '1;
                end
                else
                begin
                    state_next.countdown = state.countdown - $signed(elapsed[CD_W-1:0]);
                end
            end
            state_next.settled_flag = state_next.countdown[CD_W-1];
        end
        else
        begin
            state_next.settled_flag = 1'b0;
            state_next.countdown    = $signed({{(CD_W - 16){1'b0}}, cfg.debounce_time});
        end
        state_next.prev_sample = item.level;
        state_next.prev_time   = item.now_ms;

        // Edge detection on the settled level.
        if (state_next.settled_flag)
        begin
            if (state.prev_settled_level == inact && item.level == act && !state.press_done)
            begin
                result.pressed         = 1'b1;
                state_next.press_done  = 1'b1;
                state_next.press_start = item.now_ms;
            end
            else if (state.prev_settled_level == act && item.level == inact
                     && !state.release_done)
            begin
                result.released         = 1'b1;
                state_next.release_done = 1'b1;
                if (press_dur < {16'd0, cfg.click_window} && !state.click_done)
                begin
                    result.clicked        = 1'b1;
                    state_next.click_done = 1'b1;
                end
            end
            else
            begin
                state_next.press_done   = 1'b0;
                state_next.release_done = 1'b0;
                state_next.click_done   = 1'b0;
            end
            state_next.prev_settled_level = item.level;
        end

        result.settled = state_next.settled_flag;
        result.value   = item.level;
    end

endmodule

@@ rtl/button_debounce_click_detect.sv @@
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data   (bdc_in_t: level, now_ms)
// out      output     out_valid / out_ready  out_data  (bdc_out_t: five flags)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while out_ready stays high. An accepted item sits in the
// input register until the output register is free or being taken; then its result
// is loaded into the output register and out_valid rises. The state update is one
// short pass of logic. When out_ready is low, the output register holds and the
// input register fills; in_ready then drops until the result is taken.
// Reset clears the state and both valid flags and loads the configuration reset values.
module button_debounce_click_detect (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  bdc_pkg::bdc_in_t                       in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output bdc_pkg::bdc_out_t                      out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bdc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [bdc_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import bdc_pkg::*;

    bdc_cfg_t   cfg_reg;
    bdc_state_t state_reg;
    bdc_state_t state_next;
    bdc_in_t    in_item_reg;
    logic       in_valid_reg;
    bdc_out_t   out_item_reg;
    logic       out_valid_reg;
    bdc_out_t   result;
    logic       advance;

    // The input register moves on when the output register is free or being taken.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign cfg_ready = 1'b1;

    bdc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time <= DEBOUNCE_TIME_RST;
            cfg_reg.active_low    <= ACTIVE_LOW_RST;
            cfg_reg.click_window  <= CLICK_WINDOW_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_TIME: cfg_reg.debounce_time <= cfg_data;
                CFG_ACTIVE_LOW:    cfg_reg.active_low    <= cfg_data[0];
                CFG_CLICK_WINDOW:  cfg_reg.click_window  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    // State and output register update once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import bdc_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;
    localparam int SEG_ITEMS   = 250;

    typedef enum logic [1:0] {JOB_SAMPLE, JOB_CFG, JOB_SYNC, JOB_PHASE} job_kind_t;

    // One entry of the stimulus queue: a sample, a register write, a wait for
    // the block to drain, or a change of the idling pattern.
    typedef struct {
        job_kind_t              kind;
        bdc_in_t                smp;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        int                     idle;
        int                     stall;
        bit                     hold;
    } job_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    bdc_in_t                in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    bdc_out_t               out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    job_t        jobs[$];
    bdc_out_t    flags_q[$];
    bdc_state_t  btn;
    bdc_cfg_t    cfg_now;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_wanted = 1'b0;
    int          n_items = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          quiet = 0;
    logic [31:0] t_now;
    int unsigned dt_ms;
    int unsigned cw_ms;

    button_debounce_click_detect dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Debounce and edge detection for one sample; updates the tracked state.
    function automatic bdc_out_t debounce_predict(bdc_in_t smp);
        logic [31:0] elapsed;
        logic        act;
        bdc_out_t    r;
        act = ~cfg_now.active_low;
        r   = '0;
        if (smp.level == btn.prev_sample)
        begin
            elapsed = smp.now_ms - btn.prev_time;
            if (!btn.countdown[CD_W-1])
            begin
                if (elapsed > {14'd0, btn.countdown})
                    btn.countdown = '1;
                else
                    btn.countdown = btn.countdown - elapsed[CD_W-1:0];
            end
            btn.settled_flag = btn.countdown[CD_W-1];
        end
        else
        begin
            btn.settled_flag = 1'b0;
            btn.countdown    = {2'b00, cfg_now.debounce_time};
        end
        btn.prev_sample = smp.level;
        btn.prev_time   = smp.now_ms;

        if (btn.settled_flag)
        begin
            if (btn.prev_settled_level != act && smp.level == act && !btn.press_done)
            begin
                r.pressed       = 1'b1;
                btn.press_done  = 1'b1;
                btn.press_start = smp.now_ms;
            end
            else if (btn.prev_settled_level == act && smp.level != act && !btn.release_done)
            begin
                r.released       = 1'b1;
                btn.release_done = 1'b1;
                if ((smp.now_ms - btn.press_start) < {16'd0, cfg_now.click_window}
                    && !btn.click_done)
                begin
                    r.clicked      = 1'b1;
                    btn.click_done = 1'b1;
                end
            end
            else
            begin
                btn.press_done   = 1'b0;
                btn.release_done = 1'b0;
                btn.click_done   = 1'b0;
            end
            btn.prev_settled_level = smp.level;
        end
        r.settled = btn.settled_flag;
        r.value   = smp.level;
        return r;
    endfunction

    function automatic void write_setting(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEBOUNCE_TIME: cfg_now.debounce_time = data;
            CFG_ACTIVE_LOW:    cfg_now.active_low    = data[0];
            CFG_CLICK_WINDOW:  cfg_now.click_window  = data;
            default: ;
        endcase
    endfunction

    task automatic add_sample(input logic lv, input logic [31:0] now);
        job_t job;
        job.kind = JOB_SAMPLE;
        job.smp  = {lv, now};
        jobs     = {jobs, job};
        n_items++;
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        job_t job;
        job.kind = JOB_CFG;
        job.idx  = idx;
        job.data = data;
        jobs     = {jobs, job};
    endtask

    task automatic add_sync();
        job_t job;
        job.kind = JOB_SYNC;
        jobs     = {jobs, job};
    endtask

    task automatic add_phase(input int idle, input int stall, input bit hold);
        job_t job;
        job.kind  = JOB_PHASE;
        job.idle  = idle;
        job.stall = stall;
        job.hold  = hold;
        jobs      = {jobs, job};
    endtask

    // A bouncy move to a new level, stable samples long enough to settle
    // (usually), then a random hold time at that level.
    task automatic settle_to(input logic lv);
        int unsigned k;
        int unsigned m;
        int unsigned d;
        int unsigned h;
        int          i;
        k = $urandom_range(3);
        for (i = 0; i < k; i++)
        begin
            t_now = t_now + $urandom_range(1, 3);
            add_sample(lv ^ i[0], t_now);
        end
        t_now = t_now + $urandom_range(1, 3);
        add_sample(lv, t_now);
        m = $urandom_range(1, 4);
        d = dt_ms / m + 1 + $urandom_range(3);
        if ($urandom_range(5) == 0)
            d = d / 3;
        for (i = 0; i < m; i++)
        begin
            t_now = t_now + d;
            add_sample(lv, t_now);
        end
        h = $urandom_range(2);
        for (i = 0; i < h; i++)
        begin
            t_now = t_now + $urandom_range(0, cw_ms / 2 + 5);
            add_sample(lv, t_now);
        end
    endtask

    // Stimulus, release of reset and the end of the run.
    initial
    begin
        int   seg;
        int   goal;
        logic al;
        logic lv;

        // Directed samples at the reset settings.
        add_sample(1'b0, 32'd0);
        add_sample(1'b0, 32'd51);
        add_sample(1'b1, 32'd60);
        add_sample(1'b0, 32'd61);
        add_sample(1'b1, 32'd62);
        add_sample(1'b1, 32'd100);
        add_sample(1'b1, 32'd113);
        add_sample(1'b1, 32'd200);
        add_sample(1'b0, 32'd300);
        add_sample(1'b0, 32'd400);
        // A press longer than the click window.
        add_sample(1'b1, 32'd500);
        add_sample(1'b1, 32'd600);
        add_sample(1'b0, 32'd2000);
        add_sample(1'b0, 32'd2100);
        add_sample(1'b0, 32'd2200);
        // Press, release, press with no quiet settled sample in between.
        add_sample(1'b1, 32'd2300);
        add_sample(1'b1, 32'd2400);
        add_sample(1'b0, 32'd2500);
        add_sample(1'b0, 32'd2600);
        add_sample(1'b1, 32'd2700);
        add_sample(1'b1, 32'd2800);
        // Timer wrap, a timestamp going backwards, all ones.
        add_sample(1'b1, 32'hFFFF_FFF0);
        add_sample(1'b1, 32'h0000_0010);
        add_sample(1'b1, 32'd5);
        add_sample(1'b0, 32'hFFFF_FFFF);

        // Random segments; each one writes its settings and sets an idling pattern.
        lv = 1'b0;
        for (seg = 0; seg < 8; seg++)
        begin
            case (seg)
                0:
                begin
                    dt_ms = 5;     al = 1'b0; cw_ms = 100;
                end
                1:
                begin
                    dt_ms = 0;     al = 1'b1; cw_ms = 0;
                end
                2:
                begin
                    dt_ms = 20;    al = 1'b1; cw_ms = 65535;
                end
                3:
                begin
                    dt_ms = 65535; al = 1'b0; cw_ms = 300;
                end
                5:
                begin
                    dt_ms = 30;    al = 1'b0; cw_ms = 200;
                end
                6:
                begin
                    dt_ms = 1;     al = 1'b1; cw_ms = 65535;
                end
                default:
                begin
                    dt_ms = $urandom_range(0, 100);
                    al    = $urandom_range(1);
                    cw_ms = $urandom_range(0, 800);
                end
            endcase
            add_sync();
            add_cfg(CFG_DEBOUNCE_TIME, dt_ms[15:0]);
            add_cfg(CFG_ACTIVE_LOW, {15'($urandom()), al});
            add_cfg(CFG_CLICK_WINDOW, cw_ms[15:0]);
            case (seg % 4)
                0: add_phase(0, 0, seg == 4);
                1: add_phase(74, 0, 1'b0);
                2: add_phase(0, 74, 1'b0);
                default: add_phase(17, 17, 1'b0);
            endcase
            t_now = $urandom();
            goal  = n_items + SEG_ITEMS;
            while (n_items < goal)
            begin
                if ($urandom_range(99) < 15)
                begin
                    // Noise: random level, small step or an arbitrary jump.
                    if ($urandom_range(3) == 0)
                        t_now = t_now + $urandom();
                    else
                        t_now = t_now + $urandom_range(0, dt_ms / 4 + 3);
                    add_sample($urandom_range(1), t_now);
                end
                else
                begin
                    settle_to(lv);
                    lv = ~lv;
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_checked == n_items);
        repeat (10) @(posedge clk);
        if (n_errors == 0 && flags_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Driver: feeds samples, register writes and phase changes from the queue.
    always @(posedge clk or negedge rst_n)
    begin : driver
        job_t     job;
        bdc_out_t pred;
        logic     in_hold;
        logic     cfg_hold;
        logic     nxt_in_valid;
        logic     nxt_cfg_valid;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            btn       = '0;
            cfg_now   = {DEBOUNCE_TIME_RST, ACTIVE_LOW_RST, CLICK_WINDOW_RST};
        end
        else
        begin
            in_hold  = in_valid && !in_ready;
            cfg_hold = cfg_valid && !cfg_ready;
            if (in_valid && in_ready)
            begin
                pred    = debounce_predict(in_data);
                flags_q = {flags_q, pred};
            end
            if (cfg_valid && cfg_ready)
                write_setting(cfg_index, cfg_data);
            nxt_in_valid  = in_hold;
            nxt_cfg_valid = cfg_hold;
            if (!in_hold && !cfg_hold && jobs.size() != 0)
            begin
                job = jobs[0];
                case (job.kind)
                    JOB_SAMPLE:
                    begin
                        if ($urandom_range(99) >= idle_pct)
                        begin
                            in_data      <= job.smp;
                            nxt_in_valid = 1'b1;
                            jobs.delete(0);
                        end
                    end
                    JOB_CFG:
                    begin
                        cfg_index     <= job.idx;
                        cfg_data      <= job.data;
                        nxt_cfg_valid = 1'b1;
                        jobs.delete(0);
                    end
                    JOB_SYNC:
                    begin
                        // Registers change only once every result is back.
                        if (flags_q.size() == 0)
                            jobs.delete(0);
                    end
                    default:
                    begin
                        idle_pct    <= job.idle;
                        stall_pct   <= job.stall;
                        hold_wanted <= job.hold;
                        jobs.delete(0);
                    end
                endcase
            end
            in_valid  <= nxt_in_valid;
            cfg_valid <= nxt_cfg_valid;
        end
    end

    // Monitor: checks each result against the oldest prediction and drives
    // the receiver's ready, including one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        bdc_out_t want;
        int       hold_left;
        bit       hold_done;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (flags_q.size() == 0)
                begin
                    if (n_errors < 10)
                        $display("Unexpected result item: %b%b%b%b%b (settled value pressed released clicked)",
                                 out_data.settled, out_data.value,
                                 out_data.pressed, out_data.released, out_data.clicked);
                    n_errors++;
                end
                else
                begin
                    want = flags_q.pop_front();
                    if (out_data.settled !== want.settled || out_data.value !== want.value
                        || out_data.pressed !== want.pressed
                        || out_data.released !== want.released
                        || out_data.clicked !== want.clicked)
                    begin
                        if (n_errors < 10)
                            $display("Mismatch on result %0d: expected %b%b%b%b%b, got %b%b%b%b%b",
                                     n_checked,
                                     want.settled, want.value, want.pressed, want.released,
                                     want.clicked, out_data.settled, out_data.value,
                                     out_data.pressed, out_data.released, out_data.clicked);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            if (hold_wanted && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: ends the run when no item moves on any channel for too long.
    always @(posedge clk or negedge rst_n)
    begin : watchdog
        if (!rst_n)
            quiet <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready)
                 || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

endmodule

@@ sim.f @@
rtl/bdc_pkg.sv
rtl/bdc_step.sv
rtl/button_debounce_click_detect.sv
sim/tb_top.sv
